// File: design/pairwise_l1_distance_top_defines.svh
// Assertion macros for the pairwise L1 distance top level.
// Self-contained; each user supplies its own clock and active-low reset.
`ifndef PAIRWISE_L1_DISTANCE_TOP_DEFINES_SVH
`define PAIRWISE_L1_DISTANCE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pld assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pld assertion failed");

`endif

// File: design/pld_pkg.sv
// Package for the pairwise L1 distance block: word types, register indexes,
// operation codes and default sizes. No dependencies.
package pld_pkg;

	localparam int DEF_MAX_CENTERS = 256;
	localparam int DEF_MAX_DIM     = 64;

	localparam int ELEM_W   = 16;
	localparam int DIST_W   = 22;
	localparam int CENT_W   = 8;
	localparam int DIMIDX_W = 6;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int NCENT_CFG_W = 9;
	localparam int NDIM_CFG_W  = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTERS_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE    = 1'b1;

	localparam logic [NCENT_CFG_W-1:0] CENTERS_RESET = 9'd256;
	localparam logic [NDIM_CFG_W-1:0]  DIMS_RESET    = 7'd64;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [DIST_W-1:0] DIST_MAX = 22'h3FFFFF;

	typedef struct packed {
		logic                       op;
		logic [CENT_W-1:0]          center_a;
		logic [CENT_W-1:0]          center_b;
		logic [DIMIDX_W-1:0]        dim_index;
		logic signed [ELEM_W-1:0]   elem_value;
	} in_word_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              out_of_range;
	} out_word_t;

endpackage

// File: design/pld_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pld_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/pairwise_l1_distance_top.sv
// Top level of the pairwise L1 distance block: center store and query engine.
// Depends on pld_pkg, pld_ram and pairwise_l1_distance_top_defines.svh.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+---------------------------------
//  in      | in        | in_valid / in_ready  | in_word  (op, centers, dim, elem)
//  out     | out       | out_valid/ out_ready | out_word (distance, out_of_range)
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// A load word writes both copies of the center store; the block stays idle.
// A query walks the run, drain and done states: in run, one store read per
// dimension in use, set by the single read port of each store copy; then
// pipeline drain and result handoff. An out-of-range query goes straight to
// done and skips the reads. in_ready is low from acceptance until the result
// enters the output register, so the next word is accepted in the cycle after
// that at the earliest. A finished result sits in the output register until
// taken; the next word is accepted meanwhile, and a second query result waits
// in its final state while the register is still full. Reset clears control
// only; the store is undefined until written and has no clearing pass.
`include "pairwise_l1_distance_top_defines.svh"

module pairwise_l1_distance_top #(
	parameter int MAX_CENTERS = pld_pkg::DEF_MAX_CENTERS,
	parameter int MAX_DIM     = pld_pkg::DEF_MAX_DIM
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  pld_pkg::in_word_t                   in_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pld_pkg::out_word_t                  out_word,
	input  logic                                cfg_we,
	input  logic [pld_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pld_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import pld_pkg::*;

	localparam int DEPTH = MAX_CENTERS * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int NCW   = $clog2(MAX_CENTERS + 1);
	localparam int CNTW  = $clog2(MAX_DIM + 1);
	localparam int ABSW  = ELEM_W;
	localparam int SUMW  = ABSW + CNTW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [NCENT_CFG_W-1:0]  centers_q;
	logic [NDIM_CFG_W-1:0]   dims_q;
	logic [NCW-1:0]          ncent;
	logic [CNTW-1:0]         ndim;
	logic [CNTW-1:0]         ndim_q;
	logic [CNTW-1:0]         cnt_q;
	logic [AW-1:0]           base_a_q;
	logic [AW-1:0]           base_b_q;
	logic                    oor_q;
	logic                    valid_s1;
	logic                    valid_s2;
	logic [ABSW-1:0]         abs_s2;
	logic [SUMW-1:0]         acc_q;
	logic                    out_valid_q;
	out_word_t               out_word_q;

	logic                    in_acc;
	logic                    is_query;
	logic                    query_oor;
	logic                    load_ok;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr_a;
	logic [AW-1:0]           rd_addr_b;
	logic [ELEM_W-1:0]       rdata_a;
	logic [ELEM_W-1:0]       rdata_b;
	logic signed [ELEM_W:0]  diff;
	logic [ABSW-1:0]         abs_diff;
	logic [DIST_W-1:0]       dist_sat;
	logic                    out_free;
	logic                    handoff;

	// Configuration registers; the user must write them only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centers_q <= CENTERS_RESET;
			dims_q    <= DIMS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTERS_IN_USE: centers_q <= cfg_data;
				CFG_DIMS_IN_USE:    dims_q    <= cfg_data[NDIM_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the registers to the store's size.
	assign ncent = (32'(centers_q) > 32'(MAX_CENTERS)) ? NCW'(MAX_CENTERS) : NCW'(centers_q);
	assign ndim  = (32'(dims_q) > 32'(MAX_DIM)) ? CNTW'(MAX_DIM) : CNTW'(dims_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign is_query  = (in_word.op == OP_QUERY);
	assign query_oor = (32'(in_word.center_a) >= 32'(ncent))
		|| (32'(in_word.center_b) >= 32'(ncent));

	// Loads write both store copies at once; loads outside the store drop.
	// Loads only land in idle and reads only run in a query, so the same
	// entry is never written and read in one cycle.
	assign load_ok   = (32'(in_word.center_a) < 32'(MAX_CENTERS))
		&& (32'(in_word.dim_index) < 32'(MAX_DIM));
	assign ram_we    = in_acc && !is_query && load_ok;
	assign ram_waddr = AW'(32'(in_word.center_a) * MAX_DIM + 32'(in_word.dim_index));

	// Walk one dimension per cycle: both centers are read in parallel.
	assign rd_en     = (state_q == ST_RUN) && (cnt_q < ndim_q);
	assign rd_addr_a = base_a_q + AW'(cnt_q);
	assign rd_addr_b = base_b_q + AW'(cnt_q);

	pld_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (DEPTH)
	) u_store_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_word.elem_value),
		.re    (rd_en),
		.raddr (rd_addr_a),
		.rdata (rdata_a)
	);

	pld_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (DEPTH)
	) u_store_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_word.elem_value),
		.re    (rd_en),
		.raddr (rd_addr_b),
		.rdata (rdata_b)
	);

	// Stage 1 -> 2: signed difference and magnitude (fits in 16 bits).
	assign diff     = $signed({rdata_a[ELEM_W-1], rdata_a})
		- $signed({rdata_b[ELEM_W-1], rdata_b});
	assign abs_diff = diff[ELEM_W] ? ABSW'(-diff) : ABSW'(diff);

	// Saturate the sum into the distance field.
	assign dist_sat = (32'(acc_q) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(acc_q);

	assign out_free = !out_valid_q || out_ready;
	assign handoff  = (state_q == ST_DONE) && out_free;

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		abs_s2 <= abs_diff;
		if (in_acc && is_query) begin
			base_a_q <= AW'(32'(in_word.center_a) * MAX_DIM);
			base_b_q <= AW'(32'(in_word.center_b) * MAX_DIM);
			ndim_q   <= ndim;
			acc_q    <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + SUMW'(abs_s2);
		end
	end

	// Control: state, read counter, pipeline valids and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			oor_q       <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
		end else begin
			valid_s1 <= rd_en;
			valid_s2 <= valid_s1;
			// Load a finished result, or drop the one the consumer takes.
			if (handoff) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && is_query) begin
						cnt_q   <= '0;
						oor_q   <= query_oor;
						state_q <= query_oor ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// Wait until the last difference has been summed.
					if (!valid_s1 && !valid_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the output register is free, then hand off.
					if (handoff) begin
						out_word_q.out_of_range <= oor_q;
						out_word_q.distance     <= oor_q ? '0 : dist_sat;
						state_q                 <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// An out-of-range result always carries a zero distance.
	`PLD_ASSERT_NOW(a_oor_zero, clk, arst_n, out_valid && out_word.out_of_range,
		out_word.distance == '0)
	// No reads are in flight while new words are accepted.
	`PLD_ASSERT_NOW(a_idle_drained, clk, arst_n, in_ready, !valid_s1 && !valid_s2)
	// The read counter never passes the dimension count of the query.
	`PLD_ASSERT_NOW(a_cnt_bound, clk, arst_n, state_q == ST_RUN, cnt_q <= ndim_q)
	// An accepted query blocks the input until its result is handed off.
	`PLD_ASSERT_NEXT(a_query_busy, clk, arst_n, in_acc && is_query, !in_ready)
	// A new result only appears on leaving the final state.
	`PLD_ASSERT_NOW(a_out_source, clk, arst_n, $rose(out_valid),
		$past(state_q) == ST_DONE)

endmodule

// File: dv/l1_distance_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the pairwise L1 distance block: watches the word channels and
// the register port, mirrors the center store and checks each result word.
// Depends on pld_pkg.
module l1_distance_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  pld_pkg::in_word_t                 in_word,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  pld_pkg::out_word_t                out_word,
	input  logic                              cfg_we,
	input  logic [pld_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pld_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int unsigned                       mismatch_count,
	output int unsigned                       results_due
);
	import pld_pkg::*;

	logic signed [ELEM_W-1:0]  center_mem [DEF_MAX_CENTERS][DEF_MAX_DIM];
	logic [NCENT_CFG_W-1:0]    centers_reg;
	logic [NDIM_CFG_W-1:0]     dims_reg;
	out_word_t                 distance_due [$];

	// Sum of absolute element differences over the dimensions in use.
	function automatic out_word_t l1_distance_of(input in_word_t w);
		out_word_t   res;
		int unsigned ncent;
		int unsigned ndim;
		int unsigned sum;
		int          diff;
		res = '0;
		ncent = (centers_reg > DEF_MAX_CENTERS) ? DEF_MAX_CENTERS : centers_reg;
		ndim = (dims_reg > DEF_MAX_DIM) ? DEF_MAX_DIM : dims_reg;
		if (w.center_a >= ncent || w.center_b >= ncent) begin
			res.out_of_range = 1'b1;
			return res;
		end
		sum = 0;
		for (int d = 0; d < ndim; d++) begin
			diff = int'(center_mem[w.center_a][d]) - int'(center_mem[w.center_b][d]);
			sum += (diff < 0) ? -diff : diff;
		end
		if (sum > DIST_MAX)
			sum = DIST_MAX;
		res.distance = sum[DIST_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int unsigned errs;
		out_word_t   want;
		errs = 0;
		if (!arst_n) begin
			centers_reg <= CENTERS_RESET;
			dims_reg <= DIMS_RESET;
			distance_due.delete();
			results_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CENTERS_IN_USE: centers_reg <= cfg_data[NCENT_CFG_W-1:0];
					CFG_DIMS_IN_USE:    dims_reg <= cfg_data[NDIM_CFG_W-1:0];
					default: ;
				endcase
			end
			// Check the result first: a word accepted at this edge cannot be its source.
			if (out_valid && out_ready) begin
				if (distance_due.size() == 0) begin
					$display("%0t: result word with no query pending: distance %0d out_of_range %0b",
						$time, out_word.distance, out_word.out_of_range);
					errs++;
				end else begin
					want = distance_due.pop_front();
					if (out_word.distance !== want.distance) begin
						$display("%0t: distance mismatch: expected %0d, got %0d",
							$time, want.distance, out_word.distance);
						errs++;
					end
					if (out_word.out_of_range !== want.out_of_range) begin
						$display("%0t: out_of_range mismatch: expected %0b, got %0b",
							$time, want.out_of_range, out_word.out_of_range);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_word.op == OP_LOAD)
					center_mem[in_word.center_a][in_word.dim_index] = in_word.elem_value;
				else
					distance_due.push_back(l1_distance_of(in_word));
			end
			mismatch_count <= mismatch_count + errs;
			results_due <= distance_due.size();
		end
	end

endmodule

// File: dv/pairwise_l1_distance_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the pairwise L1 distance block: drives load and query words,
// register writes and output back-pressure; checking lives in l1_distance_checker.
// Depends on pld_pkg, l1_distance_checker and the block's RTL.
module pairwise_l1_distance_top_test;
	import pld_pkg::*;

	// Quiet time after the last pending result; well past the longest query.
	localparam int SETTLE_CYCLES  = 80;
	// Cycles without any accepted word before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;
	// Stimulus stops once both targets are met.
	localparam int WORD_TARGET    = 650;
	localparam int QUERY_TARGET   = 60;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	in_word_t                in_word = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	out_word_t               out_word;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	int unsigned             fail_count;
	int unsigned             results_due;

	// Which store entries hold a written value; queries only touch these.
	bit                      loaded [DEF_MAX_CENTERS][DEF_MAX_DIM];
	// Effective register values after saturation, mirrored for stimulus choices.
	int unsigned             centers_eff = DEF_MAX_CENTERS;
	int unsigned             dims_eff = DEF_MAX_DIM;
	int unsigned             words_sent;
	int unsigned             queries_sent;
	int                      burst_left;
	int unsigned             stall_cycles;
	int                      ready_run;
	int                      ready_mode;

	pairwise_l1_distance_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	l1_distance_checker scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_word        (in_word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_word       (out_word),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (fail_count),
		.results_due    (results_due)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: runs of steady ready, steady stall, or a choppy mix.
	always @(negedge clk) begin
		if (ready_run <= 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_run = (ready_mode == 1) ? $urandom_range(1, 24) : $urandom_range(4, 48);
		end
		ready_run--;
		case (ready_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'b0;
			default: out_ready <= ($urandom_range(0, 2) != 0);
		endcase
	end

	// Watchdog: any accepted word on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Element values: lean on the extremes, otherwise anything.
	function automatic logic signed [ELEM_W-1:0] pick_elem();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 7))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			2:       return 16'sh0000;
			default: return r[ELEM_W-1:0];
		endcase
	endfunction

	// A center may be queried only once every dimension in use was written.
	function automatic bit center_ready(input int c);
		for (int d = 0; d < dims_eff; d++)
			if (!loaded[c][d])
				return 1'b0;
		return 1'b1;
	endfunction

	// Random in-range center that is safe to query, or -1 if none is.
	function automatic int pick_ready();
		int cands [$];
		for (int c = 0; c < centers_eff; c++)
			if (center_ready(c))
				cands.push_back(c);
		if (cands.size() == 0)
			return -1;
		return cands[$urandom_range(0, cands.size() - 1)];
	endfunction

	// Drive one word and hold it until accepted. Bursts of back-to-back words
	// are separated by random gaps, at times empty; some bursts are long
	// enough to run without any idling on the input side.
	task automatic send_word(input in_word_t w);
		int gap;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		if (w.op == OP_LOAD)
			loaded[w.center_a][w.dim_index] = 1'b1;
		else
			queries_sent++;
		words_sent++;
	endtask

	task automatic load_elem(input int c, input int d, input logic signed [ELEM_W-1:0] v);
		in_word_t w;
		w.op = OP_LOAD;
		w.center_a = c[CENT_W-1:0];
		w.center_b = CENT_W'($urandom_range(0, 255));	// ignored on load; toggle it anyway
		w.dim_index = d[DIMIDX_W-1:0];
		w.elem_value = v;
		send_word(w);
	endtask

	task automatic ask_distance(input int ca, input int cb);
		in_word_t    w;
		logic [31:0] r;
		r = $urandom;
		w.op = OP_QUERY;
		w.center_a = ca[CENT_W-1:0];
		w.center_b = cb[CENT_W-1:0];
		w.dim_index = r[DIMIDX_W-1:0];	// ignored on query
		w.elem_value = r[31:16];
		send_word(w);
	endtask

	// Load the first count dimensions of a shuffled order for one center.
	task automatic load_center(input int c, input int count);
		int order [DEF_MAX_DIM];
		int j;
		int t;
		for (int i = 0; i < DEF_MAX_DIM; i++)
			order[i] = i;
		for (int i = dims_eff - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < count; i++)
			load_elem(c, order[i], pick_elem());
	endtask

	// Queries among fully loaded centers, with the odd out-of-range index mixed in.
	task automatic random_queries(input int n);
		int ca;
		int cb;
		int t;
		repeat (n) begin
			ca = pick_ready();
			cb = ($urandom_range(0, 4) == 0) ? ca : pick_ready();
			if (centers_eff < DEF_MAX_CENTERS && (ca < 0 || $urandom_range(0, 5) == 0)) begin
				ca = $urandom_range(centers_eff, DEF_MAX_CENTERS - 1);
				cb = $urandom_range(0, DEF_MAX_CENTERS - 1);
				if ($urandom_range(0, 1)) begin
					t = ca;
					ca = cb;
					cb = t;
				end
			end
			if (ca >= 0 && cb >= 0)
				ask_distance(ca, cb);
		end
	endtask

	// Drop valid, wait for every pending result, then let the engine go quiet.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write, one cycle of write enable; only call when settled.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CENTERS_IN_USE)
			centers_eff = (val > DEF_MAX_CENTERS) ? DEF_MAX_CENTERS : val;
		else
			dims_eff = (val[NDIM_CFG_W-1:0] > DEF_MAX_DIM) ? DEF_MAX_DIM : val[NDIM_CFG_W-1:0];
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] n_cent;
		logic [CFG_DATA_W-1:0] n_dim;
		int                    lc;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: one dimension, full-scale elements, symmetry and self distance.
		set_reg(CFG_DIMS_IN_USE, 9'd1);
		load_elem(0, 0, 16'sh8000);
		load_elem(255, 0, 16'sh7FFF);
		load_elem(170, 0, 16'sh5555);
		load_elem(85, 63, 16'shAAAA);
		ask_distance(0, 255);
		ask_distance(255, 0);
		ask_distance(255, 255);
		ask_distance(0, 170);
		settle();

		// One center in use: only center zero is valid.
		set_reg(CFG_CENTERS_IN_USE, 9'd1);
		ask_distance(0, 0);
		ask_distance(0, 1);
		ask_distance(255, 0);
		settle();

		// No centers in use: everything is out of range.
		set_reg(CFG_CENTERS_IN_USE, 9'd0);
		ask_distance(0, 0);
		settle();

		// No dimensions in use: valid queries sum nothing.
		set_reg(CFG_CENTERS_IN_USE, 9'd256);
		set_reg(CFG_DIMS_IN_USE, 9'd0);
		ask_distance(0, 255);
		ask_distance(170, 85);
		settle();

		// Both registers above their limits saturate; opposite full-scale vectors
		// over all dimensions give the largest distance.
		set_reg(CFG_CENTERS_IN_USE, 9'd511);
		set_reg(CFG_DIMS_IN_USE, 9'd127);
		for (int d = 0; d < DEF_MAX_DIM; d++) begin
			load_elem(0, d, 16'sh8000);
			load_elem(255, d, 16'sh7FFF);
		end
		ask_distance(0, 255);
		ask_distance(255, 0);
		ask_distance(0, 0);

		// Random phases: new settings, then rounds of center loads and queries.
		while (words_sent < WORD_TARGET || queries_sent < QUERY_TARGET) begin
			settle();
			case ($urandom_range(0, 7))
				0:       n_cent = 9'd1;
				1:       n_cent = 9'd256;
				2:       n_cent = CFG_DATA_W'($urandom_range(257, 511));
				3:       n_cent = CFG_DATA_W'($urandom_range(2, 16));
				default: n_cent = CFG_DATA_W'($urandom_range(2, 256));
			endcase
			case ($urandom_range(0, 11))
				0:       n_dim = 9'd1;
				1:       n_dim = 9'd64;
				2:       n_dim = CFG_DATA_W'($urandom_range(65, 127));
				3:       n_dim = 9'd0;
				4:       n_dim = CFG_DATA_W'($urandom_range(9, 24));
				default: n_dim = CFG_DATA_W'($urandom_range(1, 8));
			endcase
			if ($urandom_range(0, 3) != 0)
				set_reg(CFG_CENTERS_IN_USE, n_cent);
			set_reg(CFG_DIMS_IN_USE, n_dim);

			repeat ($urandom_range(2, 6)) begin
				lc = (centers_eff > 0 && $urandom_range(0, 3) != 0) ?
					$urandom_range(0, centers_eff - 1) : $urandom_range(0, DEF_MAX_CENTERS - 1);
				case ($urandom_range(0, 9))
					// Noise: stray single-element loads anywhere in the store.
					0: repeat ($urandom_range(1, 4))
						load_elem($urandom_range(0, DEF_MAX_CENTERS - 1),
							$urandom_range(0, DEF_MAX_DIM - 1), pick_elem());
					// Broken sequence: a center loaded in a random number of its dimensions, possibly all.
					1: load_center(lc, $urandom_range(0, dims_eff));
					default: load_center(lc, dims_eff);
				endcase
				random_queries($urandom_range(1, 4));
			end
		end

		settle();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/pld_pkg.sv
design/pld_ram.sv
design/pairwise_l1_distance_top.sv
dv/l1_distance_checker.sv
dv/pairwise_l1_distance_top_test.sv
